>>> rtl/core/slt_pkg.sv
`default_nettype none
package slt_pkg;

  // table geometry
  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  // field widths
  localparam int KEY_W   = 32;
  localparam int LIM_W   = 16;
  localparam int ACT_W   = 16;
  localparam int REQ_W   = 32;
  localparam int TEN_W   = 10;
  localparam int HLTH_W  = 2;
  localparam int SCORE_W = 30;
  localparam int NUM_W   = 26;
  localparam int RAW_W   = 29;

  // action codes
  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_HEALTH = 3'd2;
  localparam logic [2:0] ACT_INC    = 3'd3;
  localparam logic [2:0] ACT_DEC    = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_NOCONN   = 2'd3;

  // health codes
  localparam logic [1:0] HL_OK   = 2'd0;
  localparam logic [1:0] HL_DEGR = 2'd1;
  localparam logic [1:0] HL_OVER = 2'd2;

  // threshold register indexes and reset values
  localparam logic CFG_OVERLOAD = 1'b0;
  localparam logic CFG_DEGRADE  = 1'b1;
  localparam logic [TEN_W-1:0] OVERLOAD_RST = 10'd900;
  localparam logic [TEN_W-1:0] DEGRADE_RST  = 10'd700;

  // one table entry, held by one cell
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [LIM_W-1:0]   limit;
    logic [ACT_W-1:0]   active;
    logic [REQ_W-1:0]   requests;
    logic [TEN_W-1:0]   cpu;
    logic [TEN_W-1:0]   mem;
    logic [HLTH_W-1:0]  health;
    logic [SCORE_W-1:0] score;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/core/slt_cell.sv
`default_nettype none
// One table slot: loads its neighbor's entry on each shift step
module slt_cell (
  input  wire              clk,
  input  wire              en,
  input  slt_pkg::entry_t  din,
  output slt_pkg::entry_t  q
);

  slt_pkg::entry_t ent_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r <= din;
    end
  end

  assign q = ent_r;

endmodule
`default_nettype wire

>>> rtl/core/slt_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle
module slt_div (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  input  wire [slt_pkg::NUM_W-1:0]       num,
  input  wire [slt_pkg::LIM_W-1:0]       den,
  output logic                           done,
  output logic [slt_pkg::NUM_W-1:0]      quo
);

  localparam int CW = $clog2(slt_pkg::NUM_W);

  logic [slt_pkg::LIM_W-1:0] rem_r;
  logic [slt_pkg::NUM_W-1:0] quo_r;
  logic [slt_pkg::LIM_W-1:0] den_r;
  logic [CW-1:0]             cnt_r;
  logic                      run_r;
  logic                      done_r;
  logic [slt_pkg::LIM_W:0]   trial;
  logic                      qbit;

  // trial subtract of the next numerator bit
  always_comb begin
    trial = {rem_r, quo_r[slt_pkg::NUM_W-1]};
    qbit  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        quo_r <= num;
        den_r <= den;
      end else if (run_r) begin
        rem_r <= qbit ? slt_pkg::LIM_W'(trial - {1'b0, den_r})
                      : trial[slt_pkg::LIM_W-1:0];
        quo_r <= {quo_r[slt_pkg::NUM_W-2:0], qbit};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(slt_pkg::NUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

>>> rtl/core/server_load_table.sv
`default_nettype none
// server_load_table: table of up to SLOTS backend servers keyed by 32-bit tag.
// Input: a transaction is taken when start is high and busy is low; it carries
//   in_action (add, remove, health, inc, dec, query), in_server_key and the
//   add/health payload. One result per transaction appears on the out_ ports
//   for exactly one cycle with out_valid high; the receiver cannot stall it.
// Config: cfg_we with cfg_index 0 (overload) or 1 (degrade) writes a
//   threshold; write only while busy is low.
// Entries live in a ring of cells that rotates once per pass, SLOTS steps;
//   the entry at the head cell is examined and modified each step, and a
//   removal closes the gap during the same pass.
// Flow: a scan pass, then the result. A health update that finds its key
//   adds a division when the limit is nonzero and a second pass to store
//   the score. One transaction at a time; busy stays high until out_valid.
// Reset: the table is empty, thresholds are 900 and 700; no clearing pass.
module server_load_table (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire [2:0]                         in_action,
  input  wire [slt_pkg::KEY_W-1:0]          in_server_key,
  input  wire [slt_pkg::LIM_W-1:0]          in_conn_limit,
  input  wire [slt_pkg::TEN_W-1:0]          in_cpu_tenths,
  input  wire [slt_pkg::TEN_W-1:0]          in_mem_tenths,
  output logic                              out_valid,
  output logic [1:0]                        out_status_code,
  output logic [slt_pkg::CNT_W-1:0]         out_entry_count,
  output logic [slt_pkg::ACT_W-1:0]         out_active_now,
  output logic [slt_pkg::REQ_W-1:0]         out_requests_seen,
  output logic [slt_pkg::TEN_W-1:0]         out_cpu_now,
  output logic [slt_pkg::TEN_W-1:0]         out_mem_now,
  output logic [slt_pkg::HLTH_W-1:0]        out_health,
  output logic [slt_pkg::SCORE_W-1:0]       out_score_hundredths,
  input  wire                               cfg_we,
  input  wire                               cfg_index,
  input  wire [slt_pkg::TEN_W-1:0]          cfg_data
);

  localparam int N = slt_pkg::SLOTS;
  localparam int IW = slt_pkg::IDX_W;
  localparam int CW = slt_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DIV, S_RAW, S_MUL, S_WRITE, S_DONE
  } state_t;

  state_t state_r;

  // transaction and bookkeeping registers
  logic [2:0]                  act_r;
  logic [slt_pkg::KEY_W-1:0]   key_r;
  logic [slt_pkg::LIM_W-1:0]   lim_r;
  logic [slt_pkg::TEN_W-1:0]   cpu_r;
  logic [slt_pkg::TEN_W-1:0]   mem_r;
  logic [slt_pkg::TEN_W-1:0]   ovl_r;
  logic [slt_pkg::TEN_W-1:0]   deg_r;
  logic [CW-1:0]               fill_r;
  logic [IW-1:0]               step_r;
  logic [IW-1:0]               slot_r;
  logic                        found_r;
  logic                        gone_r;
  logic                        decz_r;
  slt_pkg::entry_t             cap_r;
  logic [slt_pkg::RAW_W-1:0]   raw_r;
  logic                        div_go_r;

  // ring of cells
  slt_pkg::entry_t             cell_q [N];
  slt_pkg::entry_t             cell_d [N];
  logic                        cell_en [N];
  slt_pkg::entry_t             head_mod;
  logic                        hit;
  logic                        add_here;
  logic                        shift;
  logic                        last_step;
  logic [slt_pkg::HLTH_W-1:0]  new_health;

  logic                        div_done;
  logic [slt_pkg::NUM_W-1:0]   div_quo;

  assign busy      = (state_r != S_IDLE);
  assign shift     = (state_r == S_SCAN) || (state_r == S_WRITE);
  assign last_step = (step_r == IW'(N - 1));

  // status from the two thresholds
  always_comb begin
    if (cpu_r > ovl_r || mem_r > ovl_r) begin
      new_health = slt_pkg::HL_OVER;
    end else if (cpu_r > deg_r || mem_r > deg_r) begin
      new_health = slt_pkg::HL_DEGR;
    end else begin
      new_health = slt_pkg::HL_OK;
    end
  end

  // head cell: examine and modify the entry passing by
  always_comb begin
    head_mod = cell_q[0];
    hit      = (state_r == S_SCAN) && !found_r && (CW'(step_r) < fill_r)
               && (cell_q[0].key == key_r) && (act_r != slt_pkg::ACT_ADD);
    add_here = (state_r == S_SCAN) && (act_r == slt_pkg::ACT_ADD)
               && (CW'(step_r) == fill_r) && (fill_r < CW'(N));
    if (add_here) begin
      head_mod = '0;
      head_mod.key   = key_r;
      head_mod.limit = lim_r;
    end else if (hit) begin
      case (act_r)
        slt_pkg::ACT_HEALTH: begin
          head_mod.cpu    = cpu_r;
          head_mod.mem    = mem_r;
          head_mod.health = new_health;
        end
        slt_pkg::ACT_INC: begin
          if (cell_q[0].active != '1) head_mod.active = cell_q[0].active + 1'b1;
          if (cell_q[0].requests != '1) begin
            head_mod.requests = cell_q[0].requests + 1'b1;
          end
        end
        slt_pkg::ACT_DEC: begin
          if (cell_q[0].active != '0) head_mod.active = cell_q[0].active - 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (state_r == S_WRITE && step_r == slot_r) begin
      head_mod.score = cap_r.score;
    end
  end

  // shift wiring; after a removal the last cell parks the dropped entry
  always_comb begin
    for (int k = 0; k < N - 1; k++) begin
      cell_d[k]  = cell_q[k + 1];
      cell_en[k] = shift;
    end
    if (gone_r) cell_d[N - 2] = head_mod;
    cell_d[N - 1]  = head_mod;
    cell_en[N - 1] = shift && !gone_r;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    slt_cell u_cell (
      .clk (clk),
      .en  (cell_en[g]),
      .din (cell_d[g]),
      .q   (cell_q[g])
    );
  end

  slt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (slt_pkg::NUM_W'(cap_r.active * 10'd1000)),
    .den   (cap_r.limit),
    .done  (div_done),
    .quo   (div_quo)
  );

  // thresholds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovl_r <= slt_pkg::OVERLOAD_RST;
      deg_r <= slt_pkg::DEGRADE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        slt_pkg::CFG_OVERLOAD: ovl_r <= cfg_data;
        slt_pkg::CFG_DEGRADE:  deg_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer, with the result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      out_valid <= 1'b0;
      div_go_r  <= 1'b0;
      found_r   <= 1'b0;
      gone_r    <= 1'b0;
      step_r    <= '0;
    end else begin
      out_valid <= 1'b0;
      div_go_r  <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            act_r   <= in_action;
            key_r   <= in_server_key;
            lim_r   <= in_conn_limit;
            cpu_r   <= in_cpu_tenths;
            mem_r   <= in_mem_tenths;
            found_r <= 1'b0;
            gone_r  <= 1'b0;
            decz_r  <= 1'b0;
            step_r  <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit || add_here) begin
            found_r <= 1'b1;
            slot_r  <= step_r;
            cap_r   <= head_mod;
            decz_r  <= (act_r == slt_pkg::ACT_DEC) && (cell_q[0].active == '0);
            if (act_r == slt_pkg::ACT_REMOVE) gone_r <= 1'b1;
          end
          step_r <= step_r + 1'b1;
          if (last_step) begin
            if (act_r == slt_pkg::ACT_HEALTH && (found_r || hit)) begin
              if ((found_r ? cap_r.limit : head_mod.limit) != '0) begin
                div_go_r <= 1'b1;
                state_r  <= S_DIV;
              end else begin
                state_r <= S_RAW;
              end
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_DIV: begin
          if (div_done) state_r <= S_RAW;
        end
        S_RAW: begin
          // load, then weighted sum
          if (cap_r.limit != '0) begin
            raw_r <= slt_pkg::RAW_W'({div_quo, 2'b00})
                   + slt_pkg::RAW_W'(cap_r.cpu * 2'd3)
                   + slt_pkg::RAW_W'({cap_r.mem, 1'b0})
                   + ((cap_r.requests != '0) ? slt_pkg::RAW_W'(10) : '0);
          end else begin
            raw_r <= slt_pkg::RAW_W'(cap_r.active * 6'd40)
                   + slt_pkg::RAW_W'(cap_r.cpu * 2'd3)
                   + slt_pkg::RAW_W'({cap_r.mem, 1'b0})
                   + ((cap_r.requests != '0) ? slt_pkg::RAW_W'(10) : '0);
          end
          state_r <= S_MUL;
        end
        S_MUL: begin
          case (cap_r.health)
            slt_pkg::HL_OVER: cap_r.score <= slt_pkg::SCORE_W'({raw_r, 1'b0});
            slt_pkg::HL_DEGR: cap_r.score <= slt_pkg::SCORE_W'({raw_r, 1'b0})
                                           + slt_pkg::SCORE_W'(raw_r);
            default:          cap_r.score <= slt_pkg::SCORE_W'(raw_r);
          endcase
          step_r  <= '0;
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          step_r <= step_r + 1'b1;
          if (last_step) state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          if (act_r == slt_pkg::ACT_ADD) begin
            out_status_code <= found_r ? slt_pkg::ST_OK : slt_pkg::ST_FULL;
          end else if (!found_r) begin
            out_status_code <= slt_pkg::ST_NOTFOUND;
          end else if (decz_r) begin
            out_status_code <= slt_pkg::ST_NOCONN;
          end else begin
            out_status_code <= slt_pkg::ST_OK;
          end
          if (act_r == slt_pkg::ACT_ADD && found_r) begin
            out_entry_count <= fill_r + 1'b1;
            fill_r          <= fill_r + 1'b1;
          end else if (act_r == slt_pkg::ACT_REMOVE && found_r) begin
            out_entry_count <= fill_r - 1'b1;
            fill_r          <= fill_r - 1'b1;
          end else begin
            out_entry_count <= fill_r;
          end
          if (found_r && act_r != slt_pkg::ACT_REMOVE) begin
            out_active_now       <= cap_r.active;
            out_requests_seen    <= cap_r.requests;
            out_cpu_now          <= cap_r.cpu;
            out_mem_now          <= cap_r.mem;
            out_health           <= cap_r.health;
            out_score_hundredths <= cap_r.score;
          end else begin
            out_active_now       <= '0;
            out_requests_seen    <= '0;
            out_cpu_now          <= '0;
            out_mem_now          <= '0;
            out_health           <= '0;
            out_score_hundredths <= '0;
          end
          gone_r  <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CW'(N)))
    else $error("entry count beyond table size");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result without a transaction in progress");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status_code == slt_pkg::ST_NOTFOUND) |->
      (out_active_now == '0 && out_score_hundredths == '0))
    else $error("missing key reported entry data");

  a_load_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> $past(state_r == S_RAW))
    else $error("score step out of order");

endmodule
`default_nettype wire
